@@ sv/four_way_junction_queue_scheduler_unit_macros.svh @@
// Assertion shorthands shared by the scheduler modules.
// Each expects clk and arst_n to be visible where it is used.
`ifndef FOUR_WAY_JUNCTION_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define FOUR_WAY_JUNCTION_QUEUE_SCHEDULER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FWJQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FWJQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fwjq_pkg.sv @@
package fwjq_pkg;

	// Configuration port geometry.
	localparam int ApbAddrW = 4;
	localparam int ApbDataW = 32;

	// Number of roads; the road fields on the ports are two bits wide.
	localparam int ROAD_COUNT = 4;

	// Register indexes on paddr[3:2].
	localparam logic [1:0] REG_PHASE_PERIOD = 2'd0;
	localparam logic [1:0] REG_START_ROAD   = 2'd1;
	localparam logic [1:0] REG_CAR_LIMIT    = 2'd2;

	// Register reset values.
	localparam logic [7:0]  PHASE_PERIOD_RST = 8'd1;
	localparam logic [1:0]  START_ROAD_RST   = 2'd0;
	localparam logic [15:0] CAR_LIMIT_RST    = 16'd200;

	// Result field widths.
	localparam int WaitW  = 32;
	localparam int CountW = 16;

	// Queue status of one word, from the queue control to the top level.
	typedef struct packed {
		logic enq;
		logic dropped;
		logic deq;
		logic bypass;
	} fwjq_qstat_t;

endpackage

@@ sv/four_way_junction_queue_scheduler_unit.sv @@
// A word accepted on start has its result strobed on done once it has passed the
// input, queue and result registers.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// Reset clears the clock, phase, queue pointers, counters and configuration registers at once;
// the arrival stamp memory is not cleared and needs no clearing pass.
module four_way_junction_queue_scheduler_unit #(
	parameter int QUEUE_DEPTH = 8,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fwjq_pkg::ApbAddrW-1:0]  paddr,
	input  logic [fwjq_pkg::ApbDataW-1:0]  pwdata,
	output logic [fwjq_pkg::ApbDataW-1:0]  prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic                           arrive,
	input  logic [1:0]                     arrive_road,
	input  logic [7:0]                     time_advance,
	output logic                           done,
	output logic                           departed,
	output logic [1:0]                     departed_road,
	output logic [fwjq_pkg::WaitW-1:0]     car_wait,
	output logic [fwjq_pkg::CountW-1:0]    cars_passed,
	output logic [fwjq_pkg::WaitW-1:0]     wait_sum,
	output logic [1:0]                     green_now,
	output logic                           arrival_dropped,
	output logic                           finished
);
	import fwjq_pkg::*;

	`include "four_way_junction_queue_scheduler_unit_macros.svh"

	localparam int RoadW = $clog2(ROAD_COUNT);
	localparam int Slots = ROAD_COUNT * QUEUE_DEPTH;
	localparam int AddrW = $clog2(Slots);
	localparam int WideW = (TIME_WIDTH > WaitW) ? TIME_WIDTH : WaitW;

	// Configuration registers.
	logic [7:0]        phase_period_q;
	logic [1:0]        start_road_q;
	logic [CountW-1:0] car_limit_q;
	logic              cfg_wr;
	logic [RoadW-1:0]  start_mod;

	// Scheduler state.
	logic [TIME_WIDTH-1:0] clock_q;
	logic [TIME_WIDTH-1:0] phase_begin_q;
	logic [RoadW-1:0]      green_q;
	logic [CountW-1:0]     passed_q;
	logic [WaitW-1:0]      wait_total_q;

	// Input stage.
	logic       valid_s1;
	logic       arrive_s1;
	logic [1:0] road_s1;
	logic [7:0] adv_s1;

	// Queue stage.
	logic                  valid_s2;
	logic                  departed_s2;
	logic                  bypass_s2;
	logic                  dropped_s2;
	logic                  finished_s2;
	logic [RoadW-1:0]      green_s2;
	logic [TIME_WIDTH-1:0] clock_s2;
	logic [CountW-1:0]     passed_s2;

	// Result registers.
	logic              done_q;
	logic              departed_q;
	logic [1:0]        departed_road_q;
	logic [WaitW-1:0]  car_wait_q;
	logic [CountW-1:0] cars_passed_q;
	logic [WaitW-1:0]  wait_sum_q;
	logic [1:0]        green_now_q;
	logic              dropped_q;
	logic              finished_q;

	// Stage one logic.
	logic [TIME_WIDTH-1:0] clock_new;
	logic [TIME_WIDTH-1:0] age;
	logic                  rotate;
	logic [RoadW-1:0]      green_next;
	logic                  serve;
	logic [CountW-1:0]     passed_next;
	fwjq_qstat_t           qst;
	logic [AddrW-1:0]      wr_addr;
	logic [AddrW-1:0]      rd_addr;
	logic [TIME_WIDTH-1:0] rd_stamp;

	// Stage two logic.
	logic [TIME_WIDTH-1:0] stamp;
	logic [TIME_WIDTH-1:0] wait_full;
	logic [WideW-1:0]      wait_ext;
	logic [WaitW-1:0]      wait_sat;
	logic [WaitW:0]        sum_wide;
	logic [WaitW-1:0]      sum_sat;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	// start_road is at most 3 and the road count at least 2, so one subtract reduces it.
	always_comb begin
		if (32'(pwdata[1:0]) >= 32'(ROAD_COUNT)) begin
			start_mod = RoadW'(32'(pwdata[1:0]) - 32'(ROAD_COUNT));
		end else begin
			start_mod = RoadW'(pwdata[1:0]);
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PHASE_PERIOD: prdata = ApbDataW'(phase_period_q);
			REG_START_ROAD:   prdata = ApbDataW'(start_road_q);
			REG_CAR_LIMIT:    prdata = ApbDataW'(car_limit_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_period_q <= PHASE_PERIOD_RST;
			start_road_q   <= START_ROAD_RST;
			car_limit_q    <= CAR_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PHASE_PERIOD: phase_period_q <= pwdata[7:0];
				REG_START_ROAD:   start_road_q   <= pwdata[1:0];
				REG_CAR_LIMIT:    car_limit_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			arrive_s1 <= arrive;
			road_s1   <= arrive_road;
			adv_s1    <= time_advance;
		end
	end

	always_comb begin
		clock_new   = clock_q + TIME_WIDTH'(adv_s1);
		age         = clock_new - phase_begin_q;
		rotate      = age >= TIME_WIDTH'(phase_period_q);
		if (rotate) begin
			green_next = (green_q == RoadW'(ROAD_COUNT - 1)) ? '0 : green_q + 1'b1;
		end else begin
			green_next = green_q;
		end
		serve       = passed_q < car_limit_q;
		passed_next = passed_q + CountW'(qst.deq);
	end

	fwjq_queue_ctrl #(
		.ROAD_COUNT (ROAD_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.RoadW      (RoadW),
		.AddrW      (AddrW)
	) u_queue_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.arrive     (arrive_s1),
		.arrive_road(road_s1),
		.green      (green_next),
		.serve      (serve),
		.st         (qst),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr)
	);

	fwjq_stamp_mem #(
		.DEPTH(Slots),
		.AW   (AddrW),
		.DW   (TIME_WIDTH)
	) u_stamp_mem (
		.clk    (clk),
		.wr_en  (valid_s1 && qst.enq),
		.wr_addr(wr_addr),
		.wr_data(clock_new),
		.rd_addr(rd_addr),
		.rd_data(rd_stamp)
	);

	// A start_road write restarts the phase; the user must write it only while no word is in flight (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q       <= '0;
			phase_begin_q <= '0;
			green_q       <= RoadW'(START_ROAD_RST);
			passed_q      <= '0;
		end else if (cfg_wr && (paddr[3:2] == REG_START_ROAD)) begin
			green_q       <= start_mod;
			phase_begin_q <= clock_q;
		end else if (valid_s1) begin
			clock_q  <= clock_new;
			green_q  <= green_next;
			passed_q <= passed_next;
			if (rotate) begin
				phase_begin_q <= clock_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			departed_s2 <= qst.deq;
			bypass_s2   <= qst.bypass;
			dropped_s2  <= qst.dropped;
			finished_s2 <= passed_next >= car_limit_q;
			green_s2    <= green_next;
			clock_s2    <= clock_new;
			passed_s2   <= passed_next;
		end
	end

	always_comb begin
		stamp     = bypass_s2 ? clock_s2 : rd_stamp;
		wait_full = departed_s2 ? clock_s2 - stamp : '0;
		wait_ext  = WideW'(wait_full);
		wait_sat  = (wait_ext > WideW'({WaitW{1'b1}})) ? '1 : wait_ext[WaitW-1:0];
		sum_wide  = {1'b0, wait_total_q} + {1'b0, wait_sat};
		sum_sat   = sum_wide[WaitW] ? '1 : sum_wide[WaitW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_total_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= valid_s2;
			if (valid_s2) begin
				wait_total_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			departed_q      <= departed_s2;
			departed_road_q <= departed_s2 ? 2'(green_s2) : 2'b0;
			car_wait_q      <= wait_sat;
			cars_passed_q   <= passed_s2;
			wait_sum_q      <= sum_sat;
			green_now_q     <= 2'(green_s2);
			dropped_q       <= dropped_s2;
			finished_q      <= finished_s2;
		end
	end

	assign done            = done_q;
	assign departed        = departed_q;
	assign departed_road   = departed_road_q;
	assign car_wait        = car_wait_q;
	assign cars_passed     = cars_passed_q;
	assign wait_sum        = wait_sum_q;
	assign green_now       = green_now_q;
	assign arrival_dropped = dropped_q;
	assign finished        = finished_q;

	`FWJQ_ASSERT_SAME(a_result_follows, start && !busy, ##3 done, "accepted word gave no result three cycles later")
	`FWJQ_ASSERT_SAME(a_idle_result, done && !departed, (car_wait == '0) && (departed_road == 2'b0), "result without departure carries a wait or a road")
	`FWJQ_ASSERT_SAME(a_limit_kept, done && departed, cars_passed <= car_limit_q, "departure counted past the car limit")
	`FWJQ_ASSERT_NEXT(a_total_grows, 1'b1, wait_total_q >= $past(wait_total_q), "total wait decreased")

endmodule

@@ sv/fwjq_stamp_mem.sv @@
module fwjq_stamp_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the slot written at the same edge returns the old data;
	// the caller bypasses that case.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ sv/fwjq_queue_ctrl.sv @@
module fwjq_queue_ctrl #(
	parameter int ROAD_COUNT  = 4,
	parameter int QUEUE_DEPTH = 8,
	parameter int RoadW       = 2,
	parameter int AddrW       = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic                    arrive,
	input  logic [1:0]              arrive_road,
	input  logic [RoadW-1:0]        green,
	input  logic                    serve,
	output fwjq_pkg::fwjq_qstat_t   st,
	output logic [AddrW-1:0]        wr_addr,
	output logic [AddrW-1:0]        rd_addr
);
	import fwjq_pkg::*;

	`include "four_way_junction_queue_scheduler_unit_macros.svh"

	localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [IdxW-1:0] head_q  [ROAD_COUNT];
	logic [IdxW-1:0] tail_q  [ROAD_COUNT];
	logic [CntW-1:0] count_q [ROAD_COUNT];

	logic [ROAD_COUNT-1:0] hit;
	logic [ROAD_COUNT-1:0] full;
	logic [ROAD_COUNT-1:0] enq_lane;
	logic [ROAD_COUNT-1:0] deq_lane;
	logic [CntW-1:0]       cnt_after [ROAD_COUNT];
	logic [IdxW-1:0]       tail_sel;
	logic [RoadW-1:0]      enq_road;
	logic                  in_range;
	logic                  deq;

	function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
		return (i == IdxW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	always_comb begin
		in_range = 32'(arrive_road) < 32'(ROAD_COUNT);
		tail_sel = '0;
		enq_road = '0;
		for (int r = 0; r < ROAD_COUNT; r++) begin
			hit[r]       = arrive && in_range && (32'(arrive_road) == r);
			full[r]      = count_q[r] == CntW'(QUEUE_DEPTH);
			enq_lane[r]  = hit[r] && !full[r];
			cnt_after[r] = count_q[r] + CntW'(enq_lane[r]);
			if (hit[r]) begin
				tail_sel = tail_q[r];
				enq_road = RoadW'(r);
			end
		end
		// The green queue is looked at after this word's arrival is in.
		deq = serve && (cnt_after[green] != '0);
		for (int r = 0; r < ROAD_COUNT; r++) begin
			deq_lane[r] = deq && (green == RoadW'(r));
		end
		wr_addr = AddrW'(enq_road) * AddrW'(QUEUE_DEPTH) + AddrW'(tail_sel);
		rd_addr = AddrW'(green) * AddrW'(QUEUE_DEPTH) + AddrW'(head_q[green]);
		st.enq     = |enq_lane;
		st.dropped = arrive && (!in_range || |(hit & full));
		st.deq     = deq;
		// Only an empty queue has its head on the slot being written.
		st.bypass  = (|enq_lane) && deq && (wr_addr == rd_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROAD_COUNT; r++) begin
				head_q[r]  <= '0;
				tail_q[r]  <= '0;
				count_q[r] <= '0;
			end
		end else if (valid) begin
			for (int r = 0; r < ROAD_COUNT; r++) begin
				if (enq_lane[r]) begin
					tail_q[r] <= ring_next(tail_q[r]);
				end
				if (deq_lane[r]) begin
					head_q[r] <= ring_next(head_q[r]);
				end
				count_q[r] <= cnt_after[r] - CntW'(deq_lane[r]);
			end
		end
	end

	for (genvar g = 0; g < ROAD_COUNT; g++) begin : g_chk
		`FWJQ_ASSERT_SAME(a_empty_aligned, count_q[g] == '0, head_q[g] == tail_q[g], "empty queue with head and tail apart")
		`FWJQ_ASSERT_SAME(a_part_apart, (count_q[g] != '0) && (count_q[g] != CntW'(QUEUE_DEPTH)), head_q[g] != tail_q[g], "partly filled queue with head on tail")
		`FWJQ_ASSERT_SAME(a_count_range, 1'b1, count_q[g] <= CntW'(QUEUE_DEPTH), "queue count beyond depth")
	end

endmodule

@@ tb/four_way_junction_queue_scheduler_unit_test.sv @@
`timescale 1ns / 1ps

module four_way_junction_queue_scheduler_unit_test;
	import fwjq_pkg::*;

	localparam int QueueDepth = 8;

	typedef struct packed {
		logic              departed;
		logic [1:0]        departed_road;
		logic [WaitW-1:0]  car_wait;
		logic [CountW-1:0] cars_passed;
		logic [WaitW-1:0]  wait_sum;
		logic [1:0]        green_now;
		logic              arrival_dropped;
		logic              finished;
	} junction_outcome_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic                arrive;
	logic [1:0]          arrive_road;
	logic [7:0]          time_advance;
	logic                done;
	logic                departed;
	logic [1:0]          departed_road;
	logic [WaitW-1:0]    car_wait;
	logic [CountW-1:0]   cars_passed;
	logic [WaitW-1:0]    wait_sum;
	logic [1:0]          green_now;
	logic                arrival_dropped;
	logic                finished;

	// Shadow of the junction: configuration, clock, queues and totals.
	logic [7:0]        cfg_phase_period;
	logic [15:0]       cfg_car_limit;
	logic [31:0]       model_clock;
	logic [31:0]       phase_origin;
	logic [1:0]        green_road;
	logic [31:0]       arrival_stamp [4][QueueDepth];
	logic [2:0]        queue_head [4];
	logic [2:0]        queue_tail [4];
	logic [3:0]        queue_fill [4];
	logic [CountW-1:0] passed_total;
	logic [WaitW-1:0]  wait_total;

	junction_outcome_t expected_outcomes[$];

	int sender_idle_pct = 0;
	int failures = 0;
	int words_sent = 0;
	int departures_seen = 0;
	int drops_seen = 0;
	int register_writes = 0;

	four_way_junction_queue_scheduler_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.arrive(arrive),
		.arrive_road(arrive_road),
		.time_advance(time_advance),
		.done(done),
		.departed(departed),
		.departed_road(departed_road),
		.car_wait(car_wait),
		.cars_passed(cars_passed),
		.wait_sum(wait_sum),
		.green_now(green_now),
		.arrival_dropped(arrival_dropped),
		.finished(finished)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic junction_outcome_t predict_outcome(input logic car_in,
			input logic [1:0] road_in, input logic [7:0] advance);
		junction_outcome_t res;
		logic [32:0]       total;
		logic [1:0]        g;
		res = '0;
		model_clock = model_clock + 32'(advance);
		if (car_in) begin
			if (queue_fill[road_in] >= 4'(QueueDepth)) begin
				res.arrival_dropped = 1'b1;
			end else begin
				arrival_stamp[road_in][queue_tail[road_in]] = model_clock;
				queue_tail[road_in] = queue_tail[road_in] + 3'd1;
				queue_fill[road_in] = queue_fill[road_in] + 4'd1;
			end
		end
		if (model_clock - phase_origin >= 32'(cfg_phase_period)) begin
			green_road = green_road + 2'd1;
			phase_origin = model_clock;
		end
		g = green_road;
		if (passed_total < cfg_car_limit && queue_fill[g] != 4'd0) begin
			res.car_wait = model_clock - arrival_stamp[g][queue_head[g]];
			queue_head[g] = queue_head[g] + 3'd1;
			queue_fill[g] = queue_fill[g] - 4'd1;
			total = {1'b0, wait_total} + {1'b0, res.car_wait};
			wait_total = total[32] ? '1 : total[31:0];
			if (passed_total != '1)
				passed_total = passed_total + 1'b1;
			res.departed = 1'b1;
			res.departed_road = g;
		end
		res.cars_passed = passed_total;
		res.wait_sum = wait_total;
		res.green_now = green_road;
		res.finished = (passed_total >= cfg_car_limit);
		return res;
	endfunction

	task automatic send_car_word(input logic car_in, input logic [1:0] road_in,
			input logic [7:0] advance);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		arrive <= car_in;
		arrive_road <= road_in;
		time_advance <= advance;
		do @(posedge clk); while (busy);
		expected_outcomes.push_back(predict_outcome(car_in, road_in, advance));
		words_sent++;
	endtask

	task automatic send_random_word();
		logic [7:0] advance;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 60)
			advance = 8'($urandom_range(7));
		else if (pick < 85)
			advance = 8'($urandom_range(255));
		else
			advance = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
		send_car_word($urandom_range(99) < 75, 2'($urandom_range(3)), advance);
	endtask

	// Lets every pending word come out before the configuration is touched.
	task automatic settle_queue();
		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
		logic [31:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (reg_index)
			REG_PHASE_PERIOD: begin
				cfg_phase_period = value[7:0];
				readback = 32'(value[7:0]);
			end
			REG_START_ROAD: begin
				green_road = value[1:0];
				phase_origin = model_clock;
				readback = 32'(value[1:0]);
			end
			REG_CAR_LIMIT: begin
				cfg_car_limit = value[15:0];
				readback = 32'(value[15:0]);
			end
			default: begin
				readback = '0;
			end
		endcase
		// The address still points at the register just written.
		if (prdata !== readback) begin
			$display("%0t: register readback expected %0d, got %0d", $time, readback, prdata);
			failures++;
		end
		register_writes++;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		junction_outcome_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				failures++;
			end else begin
				want = expected_outcomes.pop_front();
				check_field("departed", 32'(want.departed), 32'(departed));
				check_field("departed_road", 32'(want.departed_road), 32'(departed_road));
				check_field("car_wait", want.car_wait, car_wait);
				check_field("cars_passed", 32'(want.cars_passed), 32'(cars_passed));
				check_field("wait_sum", want.wait_sum, wait_sum);
				check_field("green_now", 32'(want.green_now), 32'(green_now));
				check_field("arrival_dropped", 32'(want.arrival_dropped),
					32'(arrival_dropped));
				check_field("finished", 32'(want.finished), 32'(finished));
				if (departed === 1'b1)
					departures_seen++;
				if (arrival_dropped === 1'b1)
					drops_seen++;
			end
		end
	end

	task automatic test_default_settings();
		sender_idle_pct = 20;
		send_car_word(1'b1, 2'd0, 8'd0);
		send_car_word(1'b1, 2'd1, 8'd0);
		send_car_word(1'b1, 2'd2, 8'd255);
		send_car_word(1'b1, 2'd3, 8'd1);
		send_car_word(1'b0, 2'd0, 8'd128);
		send_car_word(1'b1, 2'd2, 8'd0);
		send_car_word(1'b0, 2'd3, 8'd255);
		send_car_word(1'b1, 2'd1, 8'd85);
	endtask

	task automatic test_register_extremes();
		// A zero period moves green on every word.
		settle_queue();
		write_register(REG_PHASE_PERIOD, 32'd0);
		send_car_word(1'b1, 2'd1, 8'd0);
		send_car_word(1'b1, 2'd2, 8'd0);
		send_car_word(1'b1, 2'd3, 8'd0);

		settle_queue();
		write_register(REG_PHASE_PERIOD, 32'd255);
		send_car_word(1'b1, 2'd0, 8'd254);
		send_car_word(1'b1, 2'd0, 8'd1);

		for (int r = 0; r < 4; r++) begin
			settle_queue();
			write_register(REG_START_ROAD, 32'(r));
			send_car_word(1'b1, 2'(r), 8'd0);
		end

		settle_queue();
		write_register(REG_CAR_LIMIT, 32'd0);
		send_car_word(1'b1, green_road, 8'd3);
		send_car_word(1'b1, green_road, 8'd0);

		// A limit below the current count also stops departures.
		settle_queue();
		write_register(REG_CAR_LIMIT, 32'd1);
		send_car_word(1'b1, green_road, 8'd0);
		send_car_word(1'b0, green_road, 8'd7);

		settle_queue();
		write_register(REG_CAR_LIMIT, 32'd65535);
		send_car_word(1'b0, 2'd0, 8'd0);
		send_car_word(1'b0, 2'd0, 8'd0);
	endtask

	// Parks a full set of cars, drops the surplus, and lets the clock run ahead
	// so that the cars leave with long waits once they are let go.
	task automatic test_long_waits();
		int guard;
		settle_queue();
		sender_idle_pct = 0;
		write_register(REG_CAR_LIMIT, 32'(passed_total));
		for (int r = 0; r < 4; r++)
			for (int k = 0; k <= QueueDepth; k++)
				send_car_word(1'b1, 2'(r), 8'd0);
		repeat (150)
			send_car_word(1'b0, 2'($urandom_range(3)), 8'd255);
		settle_queue();
		write_register(REG_CAR_LIMIT, 32'd65535);
		write_register(REG_PHASE_PERIOD, 32'd0);
		guard = 0;
		while ((queue_fill[0] | queue_fill[1] | queue_fill[2] | queue_fill[3]) != 4'd0
				&& guard < 200) begin
			send_car_word(1'b0, 2'd0, 8'd255);
			guard++;
		end
	endtask

	task automatic test_random_traffic();
		int          idle_plan[3];
		int          pick;
		logic [16:0] raised;
		idle_plan = '{33, 65, 0};
		for (int p = 0; p < 3; p++) begin
			sender_idle_pct = idle_plan[p];
			for (int chunk = 0; chunk < 7; chunk++) begin
				settle_queue();
				pick = $urandom_range(9);
				write_register(REG_PHASE_PERIOD, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 :
					(pick == 2) ? 32'd255 : 32'($urandom_range(2, 254)));
				pick = $urandom_range(9);
				raised = 17'(passed_total) + 17'($urandom_range(1, 40));
				if (raised > 17'd65535)
					raised = 17'd65535;
				write_register(REG_CAR_LIMIT, (pick == 0) ? 32'd0 :
					(pick == 1) ? 32'(passed_total) :
					(pick < 5) ? 32'(raised) : 32'd65535);
				if ($urandom_range(2) == 0)
					write_register(REG_START_ROAD, 32'($urandom_range(3)));
				repeat (78) send_random_word();
			end
		end
	endtask

	// Each word drops a car on the road that turns green next, so one car leaves
	// per word until the car limit is reached.
	task automatic test_limit_reached();
		logic [16:0] target;
		int          guard;
		settle_queue();
		sender_idle_pct = 0;
		target = 17'(passed_total) + 17'd24;
		if (target > 17'd65535)
			target = 17'd65535;
		write_register(REG_PHASE_PERIOD, 32'd0);
		write_register(REG_CAR_LIMIT, 32'(target));
		guard = 0;
		while (passed_total < cfg_car_limit && guard < 100) begin
			send_car_word(1'b1, green_road + 2'd1, 8'($urandom_range(3)));
			guard++;
		end
		repeat (6) send_random_word();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		arrive = 1'b0;
		arrive_road = 2'd0;
		time_advance = 8'd0;
		cfg_phase_period = PHASE_PERIOD_RST;
		cfg_car_limit = CAR_LIMIT_RST;
		green_road = START_ROAD_RST;
		model_clock = '0;
		phase_origin = '0;
		passed_total = '0;
		wait_total = '0;
		for (int r = 0; r < 4; r++) begin
			queue_head[r] = '0;
			queue_tail[r] = '0;
			queue_fill[r] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_register_extremes();
		test_long_waits();
		test_random_traffic();
		test_limit_reached();
		settle_queue();

		$display("Sent %0d car words under %0d register writes: %0d departures, %0d drops.",
			words_sent, register_writes, departures_seen, drops_seen);
		$display("Final totals: %0d cars passed, wait sum %0d.", passed_total, wait_total);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/fwjq_pkg.sv
sv/fwjq_stamp_mem.sv
sv/fwjq_queue_ctrl.sv
sv/four_way_junction_queue_scheduler_unit.sv
tb/four_way_junction_queue_scheduler_unit_test.sv
